@@ sv/rpn_pkg.sv @@
// shared types and constants for the postfix integer stack evaluator
package rpn_pkg;

  localparam int DefStackDepth = 16;
  localparam int DataW = 32;

  typedef enum logic [3:0] {
    FN_CLEAR   = 4'd0,
    FN_PUSH    = 4'd1,
    FN_ADD     = 4'd2,
    FN_SUB     = 4'd3,
    FN_MUL     = 4'd4,
    FN_DIV     = 4'd5,
    FN_LESS    = 4'd6,
    FN_GREATER = 4'd7,
    FN_MIN     = 4'd8,
    FN_MAX     = 4'd9,
    FN_POW     = 4'd10,
    FN_SQRT    = 4'd11,
    FN_SGN     = 4'd12,
    FN_ABS     = 4'd13,
    FN_FINISH  = 4'd14,
    FN_BAD     = 4'd15
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SYNTAX  = 3'd1,
    ST_FULL    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_TYPE    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POP1, S_POP2, S_EXEC, S_ITER, S_FIN, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic rd_top;
    logic cap_t;
    logic cap_s;
    logic start;
    logic step;
    logic write;
    logic set_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic iter_done;
  } dp_sts_t;

endpackage

@@ sv/rpn_datapath.sv @@
// stack memory, operand registers and iterative arithmetic unit
module rpn_datapath import rpn_pkg::*; #(
  parameter int StackDepth = DefStackDepth,
  parameter int PtrW = $clog2(StackDepth + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  func_t             func,
  input  logic [DataW-1:0]  opnd,
  input  logic [PtrW-1:0]   sp_nxt_ctl,
  input  logic              sp_we,
  input  logic [PtrW-1:0]   rd_ptr,
  input  status_t           status_in,
  input  logic              valid_in,
  output dp_sts_t           sts,
  output logic [PtrW-1:0]   sp,
  output logic              t_bool,
  output logic              s_bool,
  output logic              s_zero,
  output logic [DataW-1:0]  res_val_o,
  output status_t           res_status_o,
  output logic              res_valid_o
);

  localparam int AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  logic [DataW:0]   mem [StackDepth];
  logic [DataW:0]   rd_r;
  logic [PtrW-1:0]  sp_r;
  logic [DataW-1:0] t_r, s_r, acc_r, acc_nxt, aux_r, aux_nxt, rem_r, rem_nxt;
  logic             tb_r, sb_r;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt, sat_r, sat_nxt;
  logic [DataW-1:0] wr_val;
  logic             wr_bool;
  logic [DataW-1:0] out_val_r;
  status_t          out_st_r;
  logic             out_valid_r;

  logic [DataW-1:0] t_mag, s_mag;
  logic [2*DataW-1:0] prod;
  logic [DataW:0]   diff;
  logic [DataW+1:0] sq_try;
  logic [DataW-1:0] lim;

  assign t_mag = t_r[DataW-1] ? (~t_r + 1'b1) : t_r;
  assign s_mag = s_r[DataW-1] ? (~s_r + 1'b1) : s_r;
  assign prod  = {{DataW{1'b0}}, aux_r} * {{DataW{1'b0}}, acc_r};
  assign lim   = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign diff  = {rem_r[DataW-2:0], acc_r[DataW-1]} - {1'b0, aux_r};
  assign sq_try = {rem_r, acc_r[DataW-1 -: 2]} - {aux_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (sp_we) begin
      sp_r <= sp_nxt_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_top) rd_r <= mem[rd_ptr[AW-1:0]];
    if (cmd.write) mem[rd_ptr[AW-1:0]] <= {wr_bool, wr_val};
  end

  always_comb begin
    acc_nxt = acc_r;
    aux_nxt = aux_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    sat_nxt = sat_r;
    if (cmd.start) begin
      cnt_nxt = 6'd0;
      sat_nxt = 1'b0;
      unique case (func)
        FN_DIV: begin
          acc_nxt = t_mag;
          aux_nxt = s_mag;
          rem_nxt = '0;
          neg_nxt = t_r[DataW-1] ^ s_r[DataW-1];
        end
        FN_SQRT: begin
          acc_nxt = t_r;
          aux_nxt = '0;
          rem_nxt = '0;
          neg_nxt = 1'b0;
        end
        default: begin
          acc_nxt = 32'd1;
          aux_nxt = s_mag;
          rem_nxt = t_r;
          neg_nxt = s_r[DataW-1] & t_r[0];
        end
      endcase
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + 6'd1;
      unique case (func)
        FN_DIV: begin
          if (!diff[DataW]) begin
            rem_nxt = diff[DataW-1:0];
            acc_nxt = {acc_r[DataW-2:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[DataW-2:0], acc_r[DataW-1]};
            acc_nxt = {acc_r[DataW-2:0], 1'b0};
          end
        end
        FN_SQRT: begin
          acc_nxt = {acc_r[DataW-3:0], 2'b00};
          if (!sq_try[DataW+1]) begin
            rem_nxt = sq_try[DataW-1:0];
            aux_nxt = {aux_r[DataW-2:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[DataW-3:0], acc_r[DataW-1 -: 2]};
            aux_nxt = {aux_r[DataW-2:0], 1'b0};
          end
        end
        default: begin
          // pow: one multiply per step, exponent counts down in rem
          if (rem_r != '0 && !sat_r) begin
            rem_nxt = rem_r - 1'b1;
            if (prod[2*DataW-1:DataW] != '0 || prod[DataW-1:0] > lim) sat_nxt = 1'b1;
            else acc_nxt = prod[DataW-1:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    wr_bool = 1'b0;
    wr_val  = '0;
    if (cmd.load_in) begin
      wr_val = opnd;
    end else begin
      unique case (func)
        FN_ADD:     wr_val = t_r + s_r;
        FN_SUB:     wr_val = t_r - s_r;
        FN_MUL:     wr_val = acc_r;
        FN_DIV:     wr_val = neg_r ? (~acc_r + 1'b1) : acc_r;
        FN_LESS: begin
          wr_val = {31'd0, $signed(t_r) < $signed(s_r)};
          wr_bool = 1'b1;
        end
        FN_GREATER: begin
          wr_val = {31'd0, $signed(t_r) > $signed(s_r)};
          wr_bool = 1'b1;
        end
        FN_MIN:     wr_val = ($signed(t_r) > $signed(s_r)) ? s_r : t_r;
        FN_MAX:     wr_val = ($signed(t_r) < $signed(s_r)) ? s_r : t_r;
        FN_POW: begin
          if (t_r == '0) wr_val = 32'd1;
          else if (t_r[DataW-1]) begin
            if (s_r == 32'd1) wr_val = 32'd1;
            else if (s_r == '1) wr_val = neg_r ? '1 : 32'd1;
            else if (s_r == '0) wr_val = 32'h7FFF_FFFF;
            else wr_val = '0;
          end else if (s_mag <= 32'd1) begin
            wr_val = neg_r ? (~s_mag + 1'b1) : s_mag;
          end else if (sat_r) begin
            wr_val = lim;
          end else begin
            wr_val = neg_r ? (~acc_r + 1'b1) : acc_r;
          end
        end
        FN_SQRT:    wr_val = t_r[DataW-1] ? '0 : aux_r;
        FN_SGN:     wr_val = (t_r == '0) ? '0 : (t_r[DataW-1] ? '1 : 32'd1);
        FN_ABS:     wr_val = t_mag;
        default:    wr_val = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_t) begin
      t_r  <= rd_r[DataW-1:0];
      tb_r <= rd_r[DataW];
    end
    if (cmd.cap_s) begin
      s_r  <= rd_r[DataW-1:0];
      sb_r <= rd_r[DataW];
    end
    if (cmd.start && func == FN_MUL) acc_r <= t_r * s_r;
    else acc_r <= acc_nxt;
    aux_r <= aux_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    sat_r <= sat_nxt;
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    if (cmd.set_out) begin
      out_val_r   <= valid_in ? t_r : '0;
      out_st_r    <= status_in;
      out_valid_r <= valid_in;
    end
  end

  always_comb begin
    unique case (func)
      FN_DIV:  sts.iter_done = cnt_r == 6'd32;
      FN_SQRT: sts.iter_done = cnt_r == 6'd16;
      FN_POW:  sts.iter_done = rem_r == '0 || sat_r || t_r[DataW-1] || s_mag <= 32'd1;
      default: sts.iter_done = 1'b1;
    endcase
  end

  assign sp           = sp_r;
  assign t_bool       = tb_r;
  assign s_bool       = sb_r;
  assign s_zero       = s_r == '0;
  assign res_val_o    = out_val_r;
  assign res_status_o = out_st_r;
  assign res_valid_o  = out_valid_r;

endmodule

@@ sv/rpn_control.sv @@
// sequencing state machine: pops, operation launch, push and result handoff
module rpn_control import rpn_pkg::*; #(
  parameter int StackDepth = DefStackDepth,
  parameter int PtrW = $clog2(StackDepth + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  func_t           func_in,
  input  logic            out_free,
  input  dp_sts_t         sts,
  input  logic [PtrW-1:0] sp,
  input  logic            t_bool,
  input  logic            s_bool,
  input  logic            s_zero,
  output dp_cmd_t         cmd,
  output func_t           func,
  output logic [PtrW-1:0] sp_nxt,
  output logic            sp_we,
  output logic [PtrW-1:0] rd_ptr,
  output status_t         status,
  output logic            res_ok,
  output logic            busy
);

  state_t  state_r, state_nxt;
  func_t   func_r;
  logic    fail_r, fail_nxt;
  logic    two_op;

  assign func   = func_r;
  assign two_op = func_r >= FN_ADD && func_r <= FN_POW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fail_r  <= 1'b0;
      func_r  <= FN_CLEAR;
    end else begin
      state_r <= state_nxt;
      fail_r  <= fail_nxt;
      if (in_fire) func_r <= func_in;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fail_nxt  = fail_r;
    cmd       = '0;
    sp_nxt    = sp;
    sp_we     = 1'b0;
    rd_ptr    = sp - 1'b1;
    status    = ST_OK;
    res_ok    = 1'b0;
    busy      = state_r != S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          fail_nxt  = 1'b0;
          state_nxt = S_POP1;
        end
      end
      S_POP1: begin
        unique case (func_r)
          FN_CLEAR: begin
            sp_nxt = '0; sp_we = 1'b1; state_nxt = S_FIN;
          end
          FN_PUSH: begin
            if (sp < PtrW'(StackDepth)) begin
              rd_ptr = sp; cmd.load_in = 1'b1; cmd.write = 1'b1;
              sp_nxt = sp + 1'b1; sp_we = 1'b1;
            end else fail_nxt = 1'b1;
            state_nxt = S_FIN;
          end
          FN_BAD: begin
            fail_nxt = 1'b1; state_nxt = S_FIN;
          end
          default: begin
            if (sp == '0) begin
              fail_nxt = 1'b1; state_nxt = S_FIN;
            end else begin
              cmd.rd_top = 1'b1; sp_nxt = sp - 1'b1; sp_we = 1'b1;
              state_nxt = S_POP2;
            end
          end
        endcase
      end
      S_POP2: begin
        cmd.cap_t = 1'b1;
        if (two_op) begin
          if (sp == '0) begin
            fail_nxt = 1'b1; state_nxt = S_FIN;
          end else begin
            cmd.rd_top = 1'b1; sp_nxt = sp - 1'b1; sp_we = 1'b1;
            state_nxt = S_EXEC;
          end
        end else state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (two_op) cmd.cap_s = 1'b1;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        // operands now held in t/s registers
        if ((t_bool && func_r != FN_FINISH) || (two_op && s_bool) ||
            (func_r == FN_FINISH && sp != '0)) begin
          fail_nxt = 1'b1; state_nxt = S_FIN;
        end else if (func_r == FN_DIV && s_zero) begin
          state_nxt = S_FIN;
        end else if (func_r == FN_FINISH) begin
          state_nxt = S_FIN;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_FIN;
          fail_nxt  = 1'b0;
          if (func_r == FN_DIV || func_r == FN_SQRT || func_r == FN_POW ||
              func_r == FN_MUL) state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // iterative units run here until done, then push
        if (!sts.iter_done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          rd_ptr = sp; cmd.write = 1'b1;
          sp_nxt = sp + 1'b1; sp_we = 1'b1;
          state_nxt = S_IDLE;
          cmd.set_out = 1'b1;
        end
      end
      S_FIN: begin
        // simple ops push here unless failed or no result
        if (out_free) begin
          if (!fail_r && two_op && !(func_r == FN_DIV && s_zero) && state_r == S_FIN &&
              func_r != FN_FINISH) begin
            rd_ptr = sp; cmd.write = 1'b1; sp_nxt = sp + 1'b1; sp_we = 1'b1;
          end else if (!fail_r && (func_r == FN_SGN || func_r == FN_ABS)) begin
            rd_ptr = sp; cmd.write = 1'b1; sp_nxt = sp + 1'b1; sp_we = 1'b1;
          end
          cmd.set_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (fail_r) begin
      unique case (func_r)
        FN_PUSH: status = ST_FULL;
        default: status = ST_SYNTAX;
      endcase
    end else if (func_r == FN_DIV && s_zero && state_r == S_FIN) status = ST_DIVZERO;
    else if (func_r == FN_FINISH && t_bool) status = ST_TYPE;
    res_ok = !fail_r && func_r == FN_FINISH && !t_bool;
  end

endmodule

@@ sv/rpn_integer_stack_evaluator.sv @@
// top level of the postfix integer stack evaluator
//
// usage:
//   in_tdata carries func (bits 3:0) and operand_value (bits 35:4); one
//   operation per transfer. out_tdata returns status, result_value,
//   result_valid and stack_depth for every accepted operation, in order.
//   sequencing by operation: clear, push, the unused code and an
//   operation on an empty stack go from the first pop state to the
//   finish state; a two-operand operation that finds one entry ends
//   after the second pop state; the other operations pass both pop states,
//   exec and iter, and mul, div (one quotient bit a cycle), sqrt (one root
//   bit a cycle) and pow (one multiply a cycle, stops on saturation) then
//   run in the output state. one operation is in flight at a time;
//   in_tready is high while the sequencer is idle, and the sequencer
//   returns to idle as the result is loaded into the output register.
//   the result register holds its item while out_tready is low; a new
//   input is taken meanwhile and its result waits in the sequencer until
//   the register frees.
//   reset empties the stack; stack contents are undefined until pushed.
module rpn_integer_stack_evaluator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = DefStackDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // func[3:0], operand_value[35:4], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status, result_value, result_valid, stack_depth, pad
);

  localparam int PtrW = $clog2(STACK_DEPTH + 1);

  dp_cmd_t         cmd;
  dp_sts_t         sts;
  func_t           func;
  logic [PtrW-1:0] sp, sp_nxt, rd_ptr;
  logic            sp_we, t_bool, s_bool, s_zero, res_ok, busy;
  status_t         status, res_status;
  logic [DataW-1:0] res_val, opnd_r;
  logic            res_valid;
  logic            out_vld_r;
  logic [PtrW-1:0] depth_r;
  logic            in_fire, out_fire, out_free;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign out_free  = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (in_fire) opnd_r <= in_tdata[35:4];
  end

  rpn_control #(.StackDepth(STACK_DEPTH)) u_ctl (
    .clk, .rst_n, .in_fire, .func_in(func_t'(in_tdata[3:0])), .out_free, .sts, .sp,
    .t_bool, .s_bool, .s_zero, .cmd, .func, .sp_nxt, .sp_we, .rd_ptr, .status,
    .res_ok, .busy
  );

  rpn_datapath #(.StackDepth(STACK_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .func, .opnd(opnd_r), .sp_nxt_ctl(sp_nxt), .sp_we, .rd_ptr,
    .status_in(status), .valid_in(res_ok), .sts, .sp, .t_bool, .s_bool, .s_zero,
    .res_val_o(res_val), .res_status_o(res_status), .res_valid_o(res_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.set_out) begin
      out_vld_r <= 1'b1;
    end else if (out_fire) begin
      out_vld_r <= 1'b0;
    end
    if (cmd.set_out) depth_r <= sp_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, 5'(depth_r), res_valid, res_val, res_status};

  assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> busy)
    else $error("accepted item did not start the sequencer");
  assert property (@(posedge clk) disable iff (!rst_n) sp <= PtrW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_out |-> !out_vld_r || out_tready)
    else $error("result overwritten before transfer");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |=> $stable(out_tdata))
    else $error("stalled result changed");

endmodule

@@ tb/rpn_integer_stack_evaluator_tb.sv @@
// self-checking testbench for the postfix integer stack evaluator
`timescale 1ns / 100ps

module rpn_integer_stack_evaluator_tb;
  import rpn_pkg::*;

  localparam int Depth = DefStackDepth;
  localparam int RandItems = 1950;
  localparam int WatchLimit = 2000;

  typedef struct packed {
    logic [4:0]  depth;
    logic        valid;
    logic [31:0] value;
    status_t     status;
  } answer_t;

  typedef struct {
    func_t       fn;
    logic [31:0] opnd;
    logic        check_typed;
    answer_t     typed;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;

  logic [31:0] stk_val [Depth];
  logic        stk_bool [Depth];
  int          stk_ptr;

  answer_t answers_due [$];
  answer_t typed_due [$];
  logic    typed_flag [$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      stim_done = 1'b0;
  bit      hold_long = 1'b0;
  int      fill_level;

  rpn_integer_stack_evaluator dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] pow_sat(logic signed [31:0] b, logic signed [31:0] e);
    logic        neg;
    logic [63:0] mag, acc, lim;
    neg = (b < 0) && e[0];
    if (e == 0) return 32'd1;
    if (e < 0) begin
      if (b == 1) return 32'd1;
      if (b == -1) return neg ? 32'hFFFF_FFFF : 32'd1;
      if (b == 0) return 32'h7FFF_FFFF;
      return 32'd0;
    end
    mag = (b < 0) ? 64'(-64'(b)) : 64'(b);
    if (mag <= 1) return neg ? -mag[31:0] : mag[31:0];
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    acc = 1;
    for (int i = 0; i < e; i++) begin
      acc = acc * mag;
      if (acc > lim) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return neg ? -acc[31:0] : acc[31:0];
  endfunction

  function automatic logic [31:0] root_floor(logic [31:0] n);
    logic [31:0] r;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      if (64'(r | (32'd1 << b)) * 64'(r | (32'd1 << b)) <= 64'(n)) r = r | (32'd1 << b);
    end
    return r;
  endfunction

  function automatic answer_t evaluate(func_t fn, logic [31:0] opnd);
    answer_t a;
    logic [31:0] tv, sv, r;
    logic signed [31:0] t, s;
    logic tb, sb, ok1, ok2, rb;
    a = '{depth: 0, valid: 0, value: 0, status: ST_OK};
    tv = 0; sv = 0; tb = 0; sb = 0; r = 0; rb = 0; ok1 = 0; ok2 = 0;
    case (fn)
      FN_CLEAR: stk_ptr = 0;
      FN_PUSH: begin
        if (stk_ptr >= Depth) a.status = ST_FULL;
        else begin
          stk_val[stk_ptr] = opnd; stk_bool[stk_ptr] = 0; stk_ptr++;
        end
      end
      FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_LESS, FN_GREATER, FN_MIN, FN_MAX, FN_POW: begin
        if (stk_ptr > 0) begin stk_ptr--; tv = stk_val[stk_ptr]; tb = stk_bool[stk_ptr]; ok1 = 1; end
        if (stk_ptr > 0) begin stk_ptr--; sv = stk_val[stk_ptr]; sb = stk_bool[stk_ptr]; ok2 = 1; end
        if (!ok1 || !ok2 || tb || sb) a.status = ST_SYNTAX;
        else begin
          t = tv; s = sv;
          case (fn)
            FN_ADD: r = tv + sv;
            FN_SUB: r = tv - sv;
            FN_MUL: r = tv * sv;
            FN_DIV: begin
              if (s == 0) a.status = ST_DIVZERO;
              else if (t == 32'sh8000_0000 && s == -1) r = 32'h8000_0000;
              else r = t / s;
            end
            FN_LESS: begin r = (t < s); rb = 1; end
            FN_GREATER: begin r = (t > s); rb = 1; end
            FN_MIN: r = (t > s) ? sv : tv;
            FN_MAX: r = (t < s) ? sv : tv;
            default: r = pow_sat(s, t);
          endcase
          if (a.status == ST_OK) begin
            stk_val[stk_ptr] = r; stk_bool[stk_ptr] = rb; stk_ptr++;
          end
        end
      end
      FN_SQRT, FN_SGN, FN_ABS: begin
        if (stk_ptr > 0) begin stk_ptr--; tv = stk_val[stk_ptr]; tb = stk_bool[stk_ptr]; ok1 = 1; end
        if (!ok1 || tb) a.status = ST_SYNTAX;
        else begin
          t = tv;
          if (fn == FN_SQRT) r = (t < 0) ? 0 : root_floor(tv);
          else if (fn == FN_SGN) r = (t == 0) ? 0 : ((t > 0) ? 32'd1 : 32'hFFFF_FFFF);
          else r = (t < 0) ? -tv : tv;
          stk_val[stk_ptr] = r; stk_bool[stk_ptr] = 0; stk_ptr++;
        end
      end
      FN_FINISH: begin
        if (stk_ptr > 0) begin stk_ptr--; tv = stk_val[stk_ptr]; tb = stk_bool[stk_ptr]; ok1 = 1; end
        if (!ok1 || stk_ptr != 0) a.status = ST_SYNTAX;
        else if (tb) a.status = ST_TYPE;
        else begin a.value = tv; a.valid = 1; end
      end
      default: a.status = ST_SYNTAX;
    endcase
    a.depth = 5'(stk_ptr);
    return a;
  endfunction

  task automatic report(string what, answer_t got, answer_t want);
    mismatches++;
    $display("mismatch %s: got st=%0d v=%0d ok=%0b d=%0d want st=%0d v=%0d ok=%0b d=%0d",
             what, got.status, $signed(got.value), got.valid, got.depth,
             want.status, $signed(want.value), want.valid, want.depth);
  endtask

  task automatic send(func_t fn, logic [31:0] opnd, logic check_typed, answer_t typed);
    int gap;
    gap = $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, opnd, fn};
    answers_due.push_back(evaluate(fn, opnd));
    typed_due.push_back(typed);
    typed_flag.push_back(check_typed);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 2);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      2: return $urandom_range(0, 3) - 1;
      3: return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    row_t rows [$];
    answer_t n;
    func_t ops [12];
    int len;
    n = '{depth: 0, valid: 0, value: 0, status: ST_OK};
    ops = '{FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_LESS, FN_GREATER, FN_MIN, FN_MAX,
            FN_POW, FN_SQRT, FN_SGN, FN_ABS};
    rows.push_back('{FN_FINISH, 0, 1, '{0, 0, 0, ST_SYNTAX}});
    rows.push_back('{FN_ADD, 0, 1, '{0, 0, 0, ST_SYNTAX}});
    rows.push_back('{FN_BAD, 32'hFFFF_FFFF, 1, '{0, 0, 0, ST_SYNTAX}});
    rows.push_back('{FN_PUSH, 32'h8000_0000, 1, '{1, 0, 0, ST_OK}});
    rows.push_back('{FN_ABS, 0, 0, n});
    rows.push_back('{FN_FINISH, 0, 1, '{0, 1, 32'h8000_0000, ST_OK}});
    rows.push_back('{FN_PUSH, 32'hFFFF_FFFF, 0, n});
    rows.push_back('{FN_PUSH, 32'h8000_0000, 0, n});
    rows.push_back('{FN_DIV, 0, 0, n});
    rows.push_back('{FN_PUSH, 0, 0, n});
    rows.push_back('{FN_PUSH, 32'd5, 0, n});
    rows.push_back('{FN_DIV, 0, 1, '{1, 0, 0, ST_DIVZERO}});
    rows.push_back('{FN_PUSH, 32'd3, 0, n});
    rows.push_back('{FN_LESS, 0, 0, n});
    rows.push_back('{FN_FINISH, 0, 1, '{0, 0, 0, ST_TYPE}});
    rows.push_back('{FN_PUSH, 32'd0, 0, n});
    rows.push_back('{FN_PUSH, 32'hFFFF_FFFF, 0, n});
    rows.push_back('{FN_POW, 0, 0, n});
    rows.push_back('{FN_PUSH, 32'hFFFF_FFF0, 0, n});
    rows.push_back('{FN_SQRT, 0, 0, n});
    rows.push_back('{FN_PUSH, 32'h7FFF_FFFF, 0, n});
    rows.push_back('{FN_SQRT, 0, 0, n});
    rows.push_back('{FN_GREATER, 0, 0, n});
    rows.push_back('{FN_CLEAR, 0, 1, '{0, 0, 0, ST_OK}});
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    stk_ptr = 0;
    foreach (rows[i]) send(rows[i].fn, rows[i].opnd, rows[i].check_typed, rows[i].typed);
    for (int i = 0; i < 17; i++) send(FN_PUSH, $urandom, 0, n);
    hold_long = 1'b1;
    for (int i = 0; i < 6; i++) send(FN_SGN, 0, 0, n);
    hold_long = 1'b0;
    send(FN_CLEAR, 0, 0, n);
    fill_level = 0;
    while (fill_level < RandItems) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 7);
        send(FN_PUSH, rand_value(), 0, n);
        for (int k = 0; k < len; k++) begin
          send(FN_PUSH, rand_value(), 0, n);
          send(ops[$urandom_range(0, 11)], $urandom, 0, n);
          if ($urandom_range(0, 3) == 0) begin
            send(ops[$urandom_range(9, 11)], $urandom, 0, n);
            fill_level++;
          end
          fill_level += 2;
        end
        send(FN_FINISH, $urandom, 0, n);
        fill_level += 2;
      end else begin
        send(func_t'($urandom_range(0, 15)), rand_value(), 0, n);
        fill_level++;
      end
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int wait_n;
    @(posedge rst_n);
    forever begin
      if (hold_long) wait_n = 300;
      else wait_n = $urandom_range(0, 14);
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[40:0];
      if (answers_due.size() == 0) begin
        mismatches++;
        $display("unexpected result transfer");
      end else begin
        want = answers_due.pop_front();
        if (typed_flag.pop_front() && got != typed_due[0]) report("table", got, typed_due[0]);
        void'(typed_due.pop_front());
        if (got.status != want.status || got.value != want.value || got.valid != want.valid
            || got.depth != want.depth) report("predicted", got, want);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    while (!(stim_done && answers_due.size() == 0) && idle_cycles < WatchLimit)
      @(posedge clk);
    if (idle_cycles >= WatchLimit) begin
      $display("Some tests failed");
    end else begin
      repeat (60) @(posedge clk);
      if (mismatches == 0 && answers_due.size() == 0) begin
        $display("All tests passed");
      end else begin
        $display("Some tests failed");
      end
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rpn_pkg.sv
sv/rpn_datapath.sv
sv/rpn_control.sv
sv/rpn_integer_stack_evaluator.sv
tb/rpn_integer_stack_evaluator_tb.sv
